FILE: rtl/lora_time_on_air_macros.svh
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion clocked on clk and disabled while arst_n is low.
`ifndef LORA_TIME_ON_AIR_MACROS_SVH
`define LORA_TIME_ON_AIR_MACROS_SVH

// Same-cycle implication.
`define LTOA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LTOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ltoa_pkg.sv
package ltoa_pkg;

	localparam int unsigned SF_W   = 4;
	localparam int unsigned BW_W   = 19;
	localparam int unsigned CR_W   = 4;
	localparam int unsigned PRE_W  = 16;
	localparam int unsigned LDRO_W = 2;
	localparam int unsigned PL_W   = 16;
	localparam int unsigned AIR_W  = 36;
	localparam int unsigned ST_W   = 2;

	// Payload block divider: divisor 4*(SF-2*LDRO), quotient up to 8 bits.
	localparam int unsigned DENA_W = 6;
	localparam int unsigned QA_W   = 8;
	// Final divider: divisor is the bandwidth, quotient is the airtime.
	localparam int unsigned DENB_W = BW_W;
	localparam int unsigned QB_W   = AIR_W;

	localparam logic [2:0] REG_SF   = 3'd0;
	localparam logic [2:0] REG_BW   = 3'd1;
	localparam logic [2:0] REG_CR   = 3'd2;
	localparam logic [2:0] REG_PRE  = 3'd3;
	localparam logic [2:0] REG_LDRO = 3'd4;
	localparam logic [2:0] REG_CRC  = 3'd5;
	localparam logic [2:0] REG_IH   = 3'd6;

	localparam logic [LDRO_W-1:0] LDRO_AUTO = 2'd0;
	localparam logic [LDRO_W-1:0] LDRO_OFF  = 2'd1;
	localparam logic [LDRO_W-1:0] LDRO_ON   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic valid;
		logic ok;
	} ltoa_ctl_t;

	function automatic logic bw_listed(input logic [BW_W-1:0] bw);
		logic hit;
		unique case (bw)
			19'd7800, 19'd10400, 19'd15600, 19'd20800, 19'd31250,
			19'd41700, 19'd62500, 19'd125000, 19'd250000, 19'd500000: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

FILE: rtl/ltoa_div_cell.sv
// One restoring division step: brings in the next dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
module ltoa_div_cell import ltoa_pkg::*; #(
	parameter int unsigned DEN_W = DENA_W,
	parameter int unsigned N     = QA_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DEN_W-1:0]   den,
	input  ltoa_ctl_t          ctl_in,
	input  logic [DEN_W+N-1:0] work_in,
	output ltoa_ctl_t          ctl_out,
	output logic [DEN_W+N-1:0] work_out
);

	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               fits;
	logic [DEN_W-1:0]   rem_next;
	ltoa_ctl_t          ctl_q;
	logic [DEN_W+N-1:0] work_q;

	assign trial    = work_in[DEN_W+N-1:N-1];
	assign diff     = trial - {1'b0, den};
	assign fits     = trial >= {1'b0, den};
	assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		work_q <= {rem_next, work_in[N-2:0], fits};
	end

	assign ctl_out  = ctl_q;
	assign work_out = work_q;

endmodule

FILE: rtl/ltoa_div_chain.sv
// Row of N division cells; the quotient comes out in the low N bits.
module ltoa_div_chain import ltoa_pkg::*; #(
	parameter int unsigned DEN_W = DENA_W,
	parameter int unsigned N     = QA_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DEN_W-1:0]   den,
	input  ltoa_ctl_t          ctl_in,
	input  logic [DEN_W+N-1:0] work_in,
	output ltoa_ctl_t          ctl_out,
	output logic [N-1:0]       quot
);

	ltoa_ctl_t          ctl_w  [0:N];
	logic [DEN_W+N-1:0] work_w [0:N];

	assign ctl_w[0]  = ctl_in;
	assign work_w[0] = work_in;

	for (genvar i = 0; i < N; i++) begin : g_cell
		ltoa_div_cell #(
			.DEN_W(DEN_W),
			.N    (N)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.den     (den),
			.ctl_in  (ctl_w[i]),
			.work_in (work_w[i]),
			.ctl_out (ctl_w[i+1]),
			.work_out(work_w[i+1])
		);
	end

	assign ctl_out = ctl_w[N];
	assign quot    = work_w[N][N-1:0];

endmodule

FILE: rtl/lora_time_on_air.sv
// A word accepted by start runs through every stage listed below in order;
// done is high for a single cycle when its result reaches the output register.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// Stages: s1, 8 division cells, s2 to s4, 36 division cells, output register.
// The receiver cannot stall, so results are shown once and never held.
// Reset (arst_n low, asynchronous) clears the pipeline and loads register defaults.
module lora_time_on_air import ltoa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PL_W-1:0]   payload_bytes,
	output logic              done,
	output logic [AIR_W-1:0]  toa_us,
	output logic [ST_W-1:0]   status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	`include "lora_time_on_air_macros.svh"

	// Configuration registers. The datapath reads them live: the user must
	// change them only while no word is in flight; the block does not enforce it.
	logic [SF_W-1:0]   sf_q;
	logic [BW_W-1:0]   bw_q;
	logic [CR_W-1:0]   cr_q;
	logic [PRE_W-1:0]  pre_q;
	logic [LDRO_W-1:0] ldro_q;
	logic              crc_q;
	logic              ih_q;
	logic [2:0]        reg_idx;
	logic              reg_wr;

	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q   <= 4'd7;
			bw_q   <= 19'd125000;
			cr_q   <= 4'd5;
			pre_q  <= 16'd8;
			ldro_q <= LDRO_AUTO;
			crc_q  <= 1'b1;
			ih_q   <= 1'b0;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_SF:   sf_q   <= pwdata[SF_W-1:0];
				REG_BW:   bw_q   <= pwdata[BW_W-1:0];
				REG_CR:   cr_q   <= pwdata[CR_W-1:0];
				REG_PRE:  pre_q  <= pwdata[PRE_W-1:0];
				REG_LDRO: ldro_q <= pwdata[LDRO_W-1:0];
				REG_CRC:  crc_q  <= pwdata[0];
				REG_IH:   ih_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SF:   prdata = {28'd0, sf_q};
			REG_BW:   prdata = {13'd0, bw_q};
			REG_CR:   prdata = {28'd0, cr_q};
			REG_PRE:  prdata = {16'd0, pre_q};
			REG_LDRO: prdata = {30'd0, ldro_q};
			REG_CRC:  prdata = {31'd0, crc_q};
			REG_IH:   prdata = {31'd0, ih_q};
			default:  prdata = 32'd0;
		endcase
	end

	// Low data rate optimization. In auto mode it is on when
	// 2^SF * 1000 >= 16 * BW, which reduces to 125 * 2^SF >= 2 * BW.
	logic [22:0]       ldro_lhs;
	logic [22:0]       ldro_rhs;
	logic              ldro_on;
	logic [SF_W-1:0]   sym_bits;
	logic [DENA_W-1:0] den_a;

	assign ldro_lhs = 23'd125 << sf_q;
	assign ldro_rhs = {3'd0, bw_q, 1'b0};
	assign ldro_on  = (ldro_q == LDRO_AUTO) ? (ldro_lhs >= ldro_rhs) : (ldro_q == LDRO_ON);
	assign sym_bits = sf_q - (ldro_on ? 4'd2 : 4'd0);
	assign den_a    = {sym_bits, 2'b00};

	// Settings check, done once per word at the front of the pipeline.
	logic accept;
	logic cfg_ok;

	assign accept = start && !busy;
	assign cfg_ok = (payload_bytes <= 16'd255) && (sf_q >= 4'd6) && (sf_q <= 4'd12)
		&& !((sf_q == 4'd6) && !ih_q) && bw_listed(bw_q)
		&& (cr_q >= 4'd5) && (cr_q <= 4'd8) && (pre_q >= 16'd6)
		&& (ldro_q <= LDRO_ON);

	// Payload bit count numerator split into its positive and negative parts
	// so that the clamp at zero is a plain compare. Adding den-1 turns the
	// truncating division in the cells into a ceiling division.
	logic [11:0] num_pos;
	logic [6:0]  num_neg;
	logic [12:0] dvd_a;

	assign num_pos = {1'b0, payload_bytes[7:0], 3'b000} + 12'd28 + (crc_q ? 12'd16 : 12'd0);
	assign num_neg = {1'b0, sf_q, 2'b00} + (ih_q ? 7'd20 : 7'd0);
	assign dvd_a   = (num_pos > {5'd0, num_neg})
		? ({1'b0, num_pos} - {6'd0, num_neg} + {7'd0, den_a} - 13'd1) : 13'd0;

	ltoa_ctl_t                ctl_s1;
	logic [DENA_W+QA_W-1:0]   work_a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: accept, ok: cfg_ok};
		end
	end

	always_ff @(posedge clk) begin
		work_a_s1 <= (DENA_W+QA_W)'(dvd_a[11:0]);
	end

	// First row of cells: payload blocks.
	ltoa_ctl_t       ctl_a;
	logic [QA_W-1:0] blocks;

	ltoa_div_chain #(
		.DEN_W(DENA_W),
		.N    (QA_W)
	) u_chain_a (
		.clk    (clk),
		.arst_n (arst_n),
		.den    (den_a),
		.ctl_in (ctl_s1),
		.work_in(work_a_s1),
		.ctl_out(ctl_a),
		.quot   (blocks)
	);

	// Quarter symbols: 4*preamble + 17 + 4*(8 + blocks*CR).
	logic [11:0] psym;
	logic [18:0] quarters;

	assign psym     = 12'd8 + 12'(blocks * cr_q);
	assign quarters = {1'b0, pre_q, 2'b00} + 19'd17 + {5'd0, psym, 2'b00};

	ltoa_ctl_t   ctl_s2;
	logic [18:0] quarters_s2;
	ltoa_ctl_t   ctl_s3;
	logic [36:0] prod_s3;
	ltoa_ctl_t   ctl_s4;
	logic [DENB_W+QB_W-1:0] work_b_s4;
	logic [47:0] dvd_b;

	// The time is quarters * 2^SF * 10^6 / (4 * BW) = quarters * 250000 * 2^SF / BW.
	assign dvd_b = {11'd0, prod_s3} << sf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_a;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		quarters_s2 <= quarters;
		prod_s3     <= 37'(quarters_s2 * 18'd250000);
		// The quotient fits 36 bits, so the top 12 dividend bits already
		// sit below the divisor and start as the partial remainder.
		work_b_s4   <= (DENB_W+QB_W)'(dvd_b);
	end

	// Second row of cells: division by the bandwidth.
	ltoa_ctl_t       ctl_b;
	logic [QB_W-1:0] air_q;

	ltoa_div_chain #(
		.DEN_W(DENB_W),
		.N    (QB_W)
	) u_chain_b (
		.clk    (clk),
		.arst_n (arst_n),
		.den    (bw_q),
		.ctl_in (ctl_s4),
		.work_in(work_b_s4),
		.ctl_out(ctl_b),
		.quot   (air_q)
	);

	// Output register: one cycle strobe per word.
	logic             done_q;
	logic [AIR_W-1:0] airtime_q;
	logic [ST_W-1:0]  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_b.valid;
		end
	end

	always_ff @(posedge clk) begin
		airtime_q <= ctl_b.ok ? air_q : '0;
		status_q  <= ctl_b.ok ? ST_OK : ST_INVALID;
	end

	assign done   = done_q;
	assign toa_us = airtime_q;
	assign status = status_q;

	`LTOA_ASSERT_NXT(a_accept_enters, accept, ctl_s1.valid, "accepted word did not enter the pipeline")
	`LTOA_ASSERT_IMP(a_bad_is_zero, done && (status != ST_OK), toa_us == '0, "nonzero time on a failed word")
	`LTOA_ASSERT_IMP(a_no_overflow, done, (status == ST_OK) || (status == ST_INVALID), "unexpected status")
	`LTOA_ASSERT_IMP(a_blocks_range, ctl_a.valid && ctl_a.ok, blocks <= 8'd131, "payload block count out of range")

endmodule

FILE: bench/lora_time_on_air_tb.sv
module lora_time_on_air_tb;
	import ltoa_pkg::*;

	// Result word as the checker sees it.
	typedef struct {
		logic [AIR_W-1:0] air;
		logic [ST_W-1:0]  st;
	} airtime_word_t;

	// The drain pause covers the whole pipeline of the block with margin.
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [PL_W-1:0]   payload_bytes;
	logic              done;
	logic [AIR_W-1:0]  toa_us;
	logic [ST_W-1:0]   status;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [4:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Local copy of the radio settings, kept in step with every register write.
	logic [SF_W-1:0]   cfg_sf;
	logic [BW_W-1:0]   cfg_bw;
	logic [CR_W-1:0]   cfg_cr;
	logic [PRE_W-1:0]  cfg_pre;
	logic [LDRO_W-1:0] cfg_ldro;
	logic              cfg_crc;
	logic              cfg_ih;

	airtime_word_t     airtime_queue[$];
	int unsigned       mismatch_count;
	int unsigned       words_sent;
	int unsigned       words_checked;
	int unsigned       ok_seen;
	longint unsigned   cycle_count;
	bit                quiet_stretch;

	// Legal bandwidths, used by the random settings.
	logic [BW_W-1:0] bw_list[10] = '{19'd7800, 19'd10400, 19'd15600, 19'd20800,
		19'd31250, 19'd41700, 19'd62500, 19'd125000, 19'd250000, 19'd500000};

	lora_time_on_air i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.payload_bytes(payload_bytes), .done(done), .toa_us(toa_us),
		.status(status), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Time on air for one payload length under the current settings. An invalid
	// setting or length gives status invalid and zero time.
	function automatic airtime_word_t airtime_calc(input logic [PL_W-1:0] plen);
		airtime_word_t     w;
		logic              legal;
		logic              ldro;
		longint            num;
		longint unsigned   den;
		longint unsigned   blocks;
		longint unsigned   quarters;
		logic [127:0]      product;
		legal = 1'b1;
		if (plen > 255) legal = 1'b0;
		if (cfg_sf < 6 || cfg_sf > 12) legal = 1'b0;
		if (cfg_sf == 6 && !cfg_ih) legal = 1'b0;
		if (!(cfg_bw inside {bw_list})) legal = 1'b0;
		if (cfg_cr < 5 || cfg_cr > 8) legal = 1'b0;
		if (cfg_pre < 6) legal = 1'b0;
		if (cfg_ldro > LDRO_ON) legal = 1'b0;
		w.air = '0;
		w.st = ST_INVALID;
		if (legal) begin
			// Auto mode turns the optimization on for long symbols.
			if (cfg_ldro == LDRO_AUTO)
				ldro = ((64'd1 << cfg_sf) * 64'd1000) >= (64'd16 * cfg_bw);
			else
				ldro = (cfg_ldro == LDRO_ON);
			num = 8 * longint'(plen) - 4 * longint'(cfg_sf) + 28
				+ (cfg_crc ? 16 : 0) - (cfg_ih ? 20 : 0);
			den = 4 * (longint'(cfg_sf) - (ldro ? 2 : 0));
			// Ceiling division, clamped at zero symbols.
			blocks = (num <= 0) ? 0 : (longint'(num) + den - 1) / den;
			quarters = 4 * longint'(cfg_pre) + 17 + 4 * (8 + blocks * cfg_cr);
			product = 128'(quarters) * (128'd1 << cfg_sf) * 128'd1000000;
			w.air = AIR_W'(product / (128'd4 * cfg_bw));
			w.st = ST_OK;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d",
			what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// Each strobed word is compared with the oldest expectation.
	always @(posedge clk) begin
		airtime_word_t want;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (done) begin
				if (airtime_queue.size() == 0) begin
					report_mismatch("unexpected word", 64'(toa_us), 64'd0);
				end else begin
					want = airtime_queue.pop_front();
					if (toa_us !== want.air)
						report_mismatch("toa_us", 64'(toa_us), 64'(want.air));
					if (status !== want.st)
						report_mismatch("status", 64'(status), 64'(want.st));
					if (want.st == ST_OK) ok_seen++;
					words_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout with %0d words outstanding", airtime_queue.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// One APB write: setup cycle then access cycle, driven on falling edges.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SF:   cfg_sf = value[SF_W-1:0];
			REG_BW:   cfg_bw = value[BW_W-1:0];
			REG_CR:   cfg_cr = value[CR_W-1:0];
			REG_PRE:  cfg_pre = value[PRE_W-1:0];
			REG_LDRO: cfg_ldro = value[LDRO_W-1:0];
			REG_CRC:  cfg_crc = value[0];
			REG_IH:   cfg_ih = value[0];
			default: ;
		endcase
	endtask

	task automatic set_radio(input int sf, input int bw, input int cr, input int pre,
		input int ldro, input int crc, input int ih);
		reg_write(REG_SF, sf);
		reg_write(REG_BW, bw);
		reg_write(REG_CR, cr);
		reg_write(REG_PRE, pre);
		reg_write(REG_LDRO, ldro);
		reg_write(REG_CRC, crc);
		reg_write(REG_IH, ih);
	endtask

	// Send one word. Outside quiet stretches the sender idles about 31% of cycles.
	// start stays high across back-to-back words, so it is only lowered on a gap.
	task automatic send_length(input logic [PL_W-1:0] plen);
		while (!quiet_stretch && $urandom_range(99) < 31) begin
			@(negedge clk);
			start <= 1'b0;
			payload_bytes <= PL_W'($urandom);
		end
		@(negedge clk);
		start <= 1'b1;
		payload_bytes <= plen;
		do @(posedge clk); while (busy);
		airtime_queue.push_back(airtime_calc(plen));
		words_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Registers may change only once the pipeline is empty.
	task automatic wait_drained();
		end_burst();
		while (airtime_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset defaults: SF7, 125 kHz, explicit header with CRC.
	task automatic test_defaults();
		send_length(0);
		send_length(255);
		send_length(256);
		send_length(16'hFFFF);
		send_length(16'h5AA5);
		wait_drained();
	endtask

	// Corners of every setting, and each invalid setting.
	task automatic test_directed_settings();
		set_radio(12, 7800, 8, 65535, LDRO_ON, 1, 0);
		send_length(255);
		send_length(0);
		wait_drained();
		// SF6 is legal only with an implicit header; the symbol count clamps at 0.
		set_radio(6, 500000, 5, 6, LDRO_OFF, 0, 1);
		send_length(0);
		send_length(1);
		send_length(255);
		wait_drained();
		reg_write(REG_IH, 0);
		send_length(10);
		wait_drained();
		// Auto mode on both sides of the long-symbol threshold.
		set_radio(11, 125000, 6, 8, LDRO_AUTO, 1, 0);
		send_length(20);
		wait_drained();
		reg_write(REG_SF, 10);
		send_length(20);
		wait_drained();
		// Each bad value in turn, restoring a good one afterwards.
		reg_write(REG_SF, 13); send_length(5); wait_drained();
		reg_write(REG_SF, 5); send_length(5); wait_drained();
		reg_write(REG_SF, 15); reg_write(REG_SF, 0); send_length(5); wait_drained();
		reg_write(REG_SF, 9);
		reg_write(REG_BW, 125001); send_length(5); wait_drained();
		reg_write(REG_BW, 32'h7FFFF); send_length(5); wait_drained();
		reg_write(REG_BW, 41700);
		reg_write(REG_CR, 4); send_length(5); wait_drained();
		reg_write(REG_CR, 15); send_length(5); wait_drained();
		reg_write(REG_CR, 7);
		reg_write(REG_PRE, 5); send_length(5); wait_drained();
		reg_write(REG_PRE, 6);
		reg_write(REG_LDRO, 3); send_length(5); wait_drained();
		// Oversized values keep only the low bits.
		reg_write(REG_LDRO, 32'hFFFF_FFFC);
		reg_write(REG_CRC, 32'hFFFF_FFFE);
		send_length(33);
		wait_drained();
	endtask

	// Mostly legal settings with random lengths, some broken settings mixed in.
	task automatic test_random_lengths();
		int   phase;
		int   k;
		int   n;
		int   sf;
		for (phase = 0; phase < 24; phase++) begin
			quiet_stretch = (phase == 5 || phase == 6);
			sf = $urandom_range(12, 6);
			set_radio(sf, int'(bw_list[$urandom_range(9)]), $urandom_range(8, 5),
				$urandom_range(99) < 20 ? $urandom : $urandom_range(64, 6),
				$urandom_range(2), $urandom_range(1),
				sf == 6 ? 1 : $urandom_range(1));
			if ($urandom_range(99) < 15)
				reg_write(3'($urandom_range(6)), $urandom);
			n = $urandom_range(34, 20);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(99) < 10)
					send_length(PL_W'($urandom));
				else
					send_length(PL_W'($urandom_range(255)));
			end
			wait_drained();
		end
		quiet_stretch = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		payload_bytes = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_sf = 4'd7;
		cfg_bw = 19'd125000;
		cfg_cr = 4'd5;
		cfg_pre = 16'd8;
		cfg_ldro = LDRO_AUTO;
		cfg_crc = 1'b1;
		cfg_ih = 1'b0;
		mismatch_count = 0;
		words_sent = 0;
		words_checked = 0;
		ok_seen = 0;
		cycle_count = 0;
		quiet_stretch = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_directed_settings();
		test_random_lengths();
		wait_drained();

		$display("Sent %0d length words, checked %0d results (%0d with status ok)",
			words_sent, words_checked, ok_seen);
		$display("Settings covered every register, legal and illegal values");
		if (mismatch_count == 0 && airtime_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
